FILE: src/stop_and_wait_sender_defines.svh
// Assertion helpers shared by the sender modules.
// Each expects clk and arst_n in the enclosing module.
`ifndef STOP_AND_WAIT_SENDER_DEFINES_SVH
`define STOP_AND_WAIT_SENDER_DEFINES_SVH

// Same-cycle implication.
`define SWS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SWS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/sws_pkg.sv
package sws_pkg;

	// Transfer phases
	localparam logic [2:0] PH_IDLE        = 3'd0;
	localparam logic [2:0] PH_WAIT_CONACC = 3'd1;
	localparam logic [2:0] PH_SENDING     = 3'd2;
	localparam logic [2:0] PH_WAIT_ACC    = 3'd3;
	localparam logic [2:0] PH_WAIT_RCVD   = 3'd4;
	localparam logic [2:0] PH_DONE        = 3'd5;
	localparam logic [2:0] PH_FAILED      = 3'd6;

	// Event kinds
	localparam logic [1:0] EV_START   = 2'd0;
	localparam logic [1:0] EV_PACKET  = 2'd1;
	localparam logic [1:0] EV_TIMEOUT = 2'd2;
	localparam logic [1:0] EV_READY   = 2'd3;

	// Received packet kinds
	localparam logic [2:0] RX_CONACC = 3'd0;
	localparam logic [2:0] RX_CONRJT = 3'd1;
	localparam logic [2:0] RX_ACC    = 3'd2;
	localparam logic [2:0] RX_RJT    = 3'd3;
	localparam logic [2:0] RX_RCVD   = 3'd4;
	localparam logic [2:0] RX_OTHER  = 3'd5;

	// Sent packet kinds
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_CONN = 2'd1;
	localparam logic [1:0] KIND_DATA = 2'd2;

	// Status codes
	localparam logic [1:0] ST_BUSY   = 2'd0;
	localparam logic [1:0] ST_DONE   = 2'd1;
	localparam logic [1:0] ST_FAILED = 2'd2;

	// Register indexes
	localparam logic [1:0] REG_RELIABLE = 2'd0;
	localparam logic [1:0] REG_MAX_RETX = 2'd1;
	localparam logic [1:0] REG_CHUNK    = 2'd2;

	// Register reset values
	localparam logic        RST_RELIABLE = 1'b1;
	localparam logic [7:0]  RST_MAX_RETX = 8'd3;
	localparam logic [15:0] RST_CHUNK    = 16'd1024;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] total_length;
		logic [63:0] new_session;
		logic [2:0]  rx_kind;
		logic [63:0] rx_session;
		logic [31:0] rx_number;
	} evt_t;

	typedef struct packed {
		logic [1:0]  send_kind;
		logic [63:0] send_session;
		logic [31:0] send_number;
		logic [31:0] send_length;
		logic [31:0] send_offset;
		logic [1:0]  status;
		logic [31:0] timeouts_seen;
	} res_t;

	typedef struct packed {
		logic        reliable_mode;
		logic [7:0]  retx_limit;
		logic [15:0] chunk_size;
	} cfg_t;

endpackage

FILE: src/sws_fsm.sv
`include "stop_and_wait_sender_defines.svh"

module sws_fsm
	import sws_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic take,
	input  evt_t evt,
	output res_t res
);

	logic [2:0]  phase_q, phase_d;
	logic [63:0] session_q, session_d;
	logic [31:0] bytes_left_q, bytes_left_d;
	logic [31:0] byte_offset_q, byte_offset_d;
	logic [15:0] chunk_bytes_q, chunk_bytes_d;
	logic [31:0] packet_number_q, packet_number_d;
	logic [7:0]  send_count_q, send_count_d;
	logic [31:0] timeout_total_q, timeout_total_d;

	logic [15:0] lim;
	logic [15:0] cut;
	logic [31:0] left_after;
	logic [31:0] offs_acked;
	logic [31:0] num_next;
	logic [31:0] to_next;
	logic        same;
	logic        can_resend;

	// Chunk cutting and shared arithmetic
	always_comb begin
		lim        = (cfg.chunk_size == 16'd0) ? 16'd1 : cfg.chunk_size;
		cut        = (bytes_left_q < {16'd0, lim}) ? bytes_left_q[15:0] : lim;
		left_after = bytes_left_q - {16'd0, cut};
		offs_acked = byte_offset_q + {16'd0, chunk_bytes_q};
		num_next   = packet_number_q + 32'd1;
		to_next    = (timeout_total_q == '1) ? timeout_total_q : timeout_total_q + 32'd1;
		same       = (evt.rx_session == session_q);
		can_resend = (send_count_q < cfg.retx_limit);
	end

	// Next state and result word
	always_comb begin
		phase_d         = phase_q;
		session_d       = session_q;
		bytes_left_d    = bytes_left_q;
		byte_offset_d   = byte_offset_q;
		chunk_bytes_d   = chunk_bytes_q;
		packet_number_d = packet_number_q;
		send_count_d    = send_count_q;
		timeout_total_d = timeout_total_q;
		res             = '0;

		unique case (phase_q)
			PH_IDLE, PH_DONE, PH_FAILED: begin
				if (evt.mode == EV_START) begin
					session_d        = evt.new_session;
					bytes_left_d     = evt.total_length;
					byte_offset_d    = '0;
					chunk_bytes_d    = '0;
					packet_number_d  = '0;
					send_count_d     = '0;
					phase_d          = PH_WAIT_CONACC;
					res.send_kind    = KIND_CONN;
					res.send_session = evt.new_session;
					res.send_length  = evt.total_length;
				end
			end
			PH_WAIT_CONACC: begin
				if (evt.mode == EV_PACKET) begin
					if (evt.rx_kind == RX_CONACC && same) begin
						if (cfg.reliable_mode) begin
							if (bytes_left_q == '0) begin
								phase_d = PH_WAIT_RCVD;
							end else begin
								chunk_bytes_d    = cut;
								bytes_left_d     = left_after;
								send_count_d     = 8'd1;
								phase_d          = PH_WAIT_ACC;
								res.send_kind    = KIND_DATA;
								res.send_session = session_q;
								res.send_number  = packet_number_q;
								res.send_length  = {16'd0, cut};
								res.send_offset  = byte_offset_q;
							end
						end else begin
							phase_d = (bytes_left_q == '0) ? PH_WAIT_RCVD : PH_SENDING;
						end
					end else begin
						phase_d = PH_FAILED;
					end
				end else if (evt.mode == EV_TIMEOUT) begin
					timeout_total_d = to_next;
					if (cfg.reliable_mode && can_resend) begin
						send_count_d     = send_count_q + 8'd1;
						res.send_kind    = KIND_CONN;
						res.send_session = session_q;
						res.send_length  = bytes_left_q;
					end else begin
						phase_d = PH_FAILED;
					end
				end
			end
			PH_SENDING: begin
				// plain mode: one chunk per link-ready event
				if (evt.mode == EV_READY) begin
					chunk_bytes_d    = cut;
					bytes_left_d     = left_after;
					byte_offset_d    = byte_offset_q + {16'd0, cut};
					packet_number_d  = num_next;
					res.send_kind    = KIND_DATA;
					res.send_session = session_q;
					res.send_number  = packet_number_q;
					res.send_length  = {16'd0, cut};
					res.send_offset  = byte_offset_q;
					if (left_after == '0) begin
						phase_d = PH_WAIT_RCVD;
					end
				end
			end
			PH_WAIT_ACC: begin
				if (evt.mode == EV_PACKET && evt.rx_kind == RX_RJT) begin
					phase_d = PH_FAILED;
				end else if (evt.mode == EV_PACKET && evt.rx_kind == RX_ACC && same &&
						evt.rx_number == packet_number_q) begin
					// acknowledged: step past the chunk, cut the next one
					byte_offset_d   = offs_acked;
					packet_number_d = num_next;
					if (bytes_left_q == '0) begin
						phase_d = PH_WAIT_RCVD;
					end else begin
						chunk_bytes_d    = cut;
						bytes_left_d     = left_after;
						send_count_d     = 8'd1;
						res.send_kind    = KIND_DATA;
						res.send_session = session_q;
						res.send_number  = num_next;
						res.send_length  = {16'd0, cut};
						res.send_offset  = offs_acked;
					end
				end else if (evt.mode == EV_PACKET || evt.mode == EV_TIMEOUT) begin
					if (evt.mode == EV_TIMEOUT) begin
						timeout_total_d = to_next;
					end
					if (can_resend) begin
						send_count_d     = send_count_q + 8'd1;
						res.send_kind    = KIND_DATA;
						res.send_session = session_q;
						res.send_number  = packet_number_q;
						res.send_length  = {16'd0, chunk_bytes_q};
						res.send_offset  = byte_offset_q;
					end else begin
						phase_d = PH_FAILED;
					end
				end
			end
			PH_WAIT_RCVD: begin
				if (evt.mode == EV_PACKET) begin
					phase_d = (evt.rx_kind == RX_RCVD && same) ? PH_DONE : PH_FAILED;
				end else if (evt.mode == EV_TIMEOUT) begin
					timeout_total_d = to_next;
					phase_d         = PH_FAILED;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		res.status        = (phase_d == PH_DONE) ? ST_DONE :
				(phase_d == PH_FAILED) ? ST_FAILED : ST_BUSY;
		res.timeouts_seen = timeout_total_d;
	end

	// State registers, updated per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_IDLE;
			session_q       <= '0;
			bytes_left_q    <= '0;
			byte_offset_q   <= '0;
			chunk_bytes_q   <= '0;
			packet_number_q <= '0;
			send_count_q    <= '0;
			timeout_total_q <= '0;
		end else if (take) begin
			phase_q         <= phase_d;
			session_q       <= session_d;
			bytes_left_q    <= bytes_left_d;
			byte_offset_q   <= byte_offset_d;
			chunk_bytes_q   <= chunk_bytes_d;
			packet_number_q <= packet_number_d;
			send_count_q    <= send_count_d;
			timeout_total_q <= timeout_total_d;
		end
	end

	`SWS_ASSERT_NXT(a_to_monotonic, 1'b1, timeout_total_q >= $past(timeout_total_q),
		"timeout count went backward")
	`SWS_ASSERT_IMP(a_acc_has_send, phase_q == PH_WAIT_ACC, send_count_q != 8'd0,
		"waiting for ACC with no send made")
	`SWS_ASSERT_NXT(a_idle_hold, !take, phase_q == $past(phase_q),
		"phase moved without an accepted word")

endmodule

FILE: src/sws_obuf.sv
`include "stop_and_wait_sender_defines.svh"

module sws_obuf
	import sws_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t push_word,
	output logic full,
	output logic out_valid,
	input  logic out_stall,
	output res_t out_word
);

	logic main_valid_q;
	logic skid_valid_q;
	res_t main_q;
	res_t skid_q;

	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_word  = main_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!main_valid_q || !out_stall) begin
			main_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Result and skid words
	always_ff @(posedge clk) begin
		if (!main_valid_q || !out_stall) begin
			main_q <= skid_valid_q ? skid_q : push_word;
		end else if (push) begin
			skid_q <= push_word;
		end
	end

	`SWS_ASSERT_IMP(a_skid_order, skid_valid_q, main_valid_q,
		"skid word held with empty result register")
	`SWS_ASSERT_NXT(a_no_drop, push && main_valid_q && out_stall, skid_valid_q,
		"word pushed into a stalled buffer was dropped")
	`SWS_ASSERT_IMP(a_no_overrun, skid_valid_q, !push,
		"word pushed while buffer full")

endmodule

FILE: src/stop_and_wait_sender.sv
// Stop-and-wait sender controller.
// Each accepted event word yields one result word on res. Throughput: one event
// per cycle while evt_stall is low; the state update is a single pass of
// compares and 32-bit adds between the input handshake and the result register.
// Reset (arst_n low): transfer state idle, counters zero, registers to defaults.
module stop_and_wait_sender
	import sws_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        evt_valid,
	output logic        evt_stall,
	input  evt_t        evt,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t cfg_q;
	res_t next_res;
	logic take;

	assign cfg_ready = 1'b1;
	assign take      = evt_valid && !evt_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reliable_mode <= RST_RELIABLE;
			cfg_q.retx_limit    <= RST_MAX_RETX;
			cfg_q.chunk_size    <= RST_CHUNK;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RELIABLE: cfg_q.reliable_mode <= cfg_data[0];
				REG_MAX_RETX: cfg_q.retx_limit    <= cfg_data[7:0];
				REG_CHUNK:    cfg_q.chunk_size    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sws_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.take   (take),
		.evt    (evt),
		.res    (next_res)
	);

	sws_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_word (next_res),
		.full      (evt_stall),
		.out_valid (res_valid),
		.out_stall (res_stall),
		.out_word  (res)
	);

endmodule

FILE: tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sws_pkg::*;

	localparam int N_PHASES        = 12;
	localparam int ITEMS_PER_PHASE = 134;
	localparam int LIMIT_NS        = 5_000_000;
	localparam int MAX_SHOWN       = 10;

	localparam logic [1:0]  REG_UNUSED = 2'd3;
	localparam logic [2:0]  RX_SPARE   = 3'd7;
	localparam logic [63:0] ONES64     = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [31:0] ONES32     = 32'hFFFF_FFFF;

	typedef struct packed {
		evt_t       e;
		logic       typed;
		res_t       r;
	} vector_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        evt_valid = 1'b0;
	logic        evt_stall;
	evt_t        evt = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	res_t        res;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	stop_and_wait_sender uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Shadow registers
	logic        cfg_reliable = RST_RELIABLE;
	logic [7:0]  cfg_max_retx = RST_MAX_RETX;
	logic [15:0] cfg_chunk    = RST_CHUNK;

	// Shadow transfer state
	logic [2:0]  ph = PH_IDLE;
	logic [63:0] cur_session = '0;
	logic [31:0] bytes_left = '0;
	logic [31:0] byte_offset = '0;
	logic [15:0] chunk_bytes = '0;
	logic [31:0] pkt_num = '0;
	logic [7:0]  send_cnt = '0;
	logic [31:0] timeout_total = '0;

	res_t pred;
	logic pred_ignored;
	res_t awaited_results[$];
	res_t want;
	vector_t dir_rows[$];

	int n_events = 0, n_directed = 0, n_live = 0, n_checked = 0;
	int n_starts = 0, n_done = 0, n_failed = 0;
	int failures = 0, shown = 0;
	int idle_pct = 0, stall_pct = 0, stall_left = 0;
	bit quiet = 1'b0;

	// DATA word for the current chunk
	function automatic void emit_chunk();
		pred.send_kind    = KIND_DATA;
		pred.send_session = cur_session;
		pred.send_number  = pkt_num;
		pred.send_length  = {16'd0, chunk_bytes};
		pred.send_offset  = byte_offset;
	endfunction

	// Next chunk off the remaining bytes; size 0 behaves as 1
	function automatic void cut_chunk();
		logic [15:0] lim;
		lim = (cfg_chunk == 16'd0) ? 16'd1 : cfg_chunk;
		chunk_bytes = (bytes_left < {16'd0, lim}) ? bytes_left[15:0] : lim;
		bytes_left = bytes_left - {16'd0, chunk_bytes};
	endfunction

	function automatic void next_chunk_or_wait();
		if (bytes_left == 32'd0) begin
			ph = PH_WAIT_RCVD;
		end else begin
			cut_chunk();
			send_cnt = 8'd1;
			ph = PH_WAIT_ACC;
			emit_chunk();
		end
	endfunction

	function automatic void count_timeout();
		if (timeout_total != ONES32) timeout_total = timeout_total + 32'd1;
	endfunction

	function automatic void resend_or_fail();
		if (send_cnt < cfg_max_retx) begin
			send_cnt = send_cnt + 8'd1;
			emit_chunk();
		end else begin
			ph = PH_FAILED;
		end
	endfunction

	// Advance the shadow sender by one event word; result lands in pred
	function automatic void step_sender(evt_t e);
		logic same;
		same = (e.rx_session == cur_session);
		pred = '0;
		pred_ignored = 1'b1;
		case (ph)
			PH_IDLE, PH_DONE, PH_FAILED: begin
				if (e.mode == EV_START) begin
					pred_ignored = 1'b0;
					cur_session = e.new_session;
					bytes_left = e.total_length;
					byte_offset = '0;
					chunk_bytes = '0;
					pkt_num = '0;
					send_cnt = '0;
					ph = PH_WAIT_CONACC;
					pred.send_kind = KIND_CONN;
					pred.send_session = cur_session;
					pred.send_length = bytes_left;
				end
			end
			PH_WAIT_CONACC: begin
				if (e.mode == EV_PACKET) begin
					pred_ignored = 1'b0;
					if (e.rx_kind == RX_CONACC && same) begin
						if (cfg_reliable) next_chunk_or_wait();
						else ph = (bytes_left == 32'd0) ? PH_WAIT_RCVD : PH_SENDING;
					end else begin
						ph = PH_FAILED;
					end
				end else if (e.mode == EV_TIMEOUT) begin
					pred_ignored = 1'b0;
					count_timeout();
					if (cfg_reliable && send_cnt < cfg_max_retx) begin
						send_cnt = send_cnt + 8'd1;
						pred.send_kind = KIND_CONN;
						pred.send_session = cur_session;
						pred.send_length = bytes_left;
					end else begin
						ph = PH_FAILED;
					end
				end
			end
			PH_SENDING: begin
				if (e.mode == EV_READY) begin
					pred_ignored = 1'b0;
					cut_chunk();
					emit_chunk();
					byte_offset = byte_offset + {16'd0, chunk_bytes};
					pkt_num = pkt_num + 32'd1;
					if (bytes_left == 32'd0) ph = PH_WAIT_RCVD;
				end
			end
			PH_WAIT_ACC: begin
				if (e.mode == EV_PACKET) begin
					pred_ignored = 1'b0;
					if (e.rx_kind == RX_RJT) begin
						ph = PH_FAILED;
					end else if (e.rx_kind == RX_ACC && same && e.rx_number == pkt_num) begin
						byte_offset = byte_offset + {16'd0, chunk_bytes};
						pkt_num = pkt_num + 32'd1;
						next_chunk_or_wait();
					end else begin
						resend_or_fail();
					end
				end else if (e.mode == EV_TIMEOUT) begin
					pred_ignored = 1'b0;
					count_timeout();
					resend_or_fail();
				end
			end
			PH_WAIT_RCVD: begin
				if (e.mode == EV_PACKET) begin
					pred_ignored = 1'b0;
					ph = (e.rx_kind == RX_RCVD && same) ? PH_DONE : PH_FAILED;
				end else if (e.mode == EV_TIMEOUT) begin
					pred_ignored = 1'b0;
					count_timeout();
					ph = PH_FAILED;
				end
			end
			default: ph = PH_IDLE;
		endcase
		pred.status = (ph == PH_DONE) ? ST_DONE : (ph == PH_FAILED) ? ST_FAILED : ST_BUSY;
		pred.timeouts_seen = timeout_total;
	endfunction

	function automatic evt_t event_word(logic [1:0] mode, logic [31:0] total,
			logic [63:0] sess, logic [2:0] kind, logic [63:0] rsess, logic [31:0] rnum);
		evt_t e;
		e.mode = mode;
		e.total_length = total;
		e.new_session = sess;
		e.rx_kind = kind;
		e.rx_session = rsess;
		e.rx_number = rnum;
		return e;
	endfunction

	function automatic res_t result_word(logic [1:0] kind, logic [63:0] sess,
			logic [31:0] num, logic [31:0] len, logic [31:0] off, logic [1:0] st,
			logic [31:0] tos);
		res_t r;
		r.send_kind = kind;
		r.send_session = sess;
		r.send_number = num;
		r.send_length = len;
		r.send_offset = off;
		r.status = st;
		r.timeouts_seen = tos;
		return r;
	endfunction

	function automatic string describe(res_t r);
		return $sformatf("kind=%0d session=%h number=%0d length=%0d offset=%0d status=%0d timeouts=%0d",
			r.send_kind, r.send_session, r.send_number, r.send_length, r.send_offset,
			r.status, r.timeouts_seen);
	endfunction

	// Fully random word; also the noise mixed into transfers
	function automatic evt_t noise_event();
		evt_t e;
		e.mode = 2'($urandom_range(0, 3));
		e.total_length = $urandom;
		e.new_session = {$urandom, $urandom};
		e.rx_kind = 3'($urandom_range(0, 7));
		e.rx_session = {$urandom, $urandom};
		e.rx_number = $urandom;
		return e;
	endfunction

	// Mostly the word a well-behaved peer would send next, otherwise noise
	function automatic evt_t next_stimulus();
		evt_t e;
		int pick;
		logic [31:0] lim;
		e = noise_event();
		pick = $urandom_range(0, 99);
		lim = (cfg_chunk == 16'd0) ? 32'd1 : {16'd0, cfg_chunk};
		case (ph)
			PH_IDLE, PH_DONE, PH_FAILED: begin
				if (pick < 85) begin
					e.mode = EV_START;
					if (!(pick < 4 && cfg_reliable))
						e.total_length = lim * $urandom_range(0, 4) + $urandom_range(0, lim);
				end
			end
			PH_WAIT_CONACC: begin
				// a huge plain transfer would never end, so end it here
				if (!cfg_reliable && bytes_left > (lim << 6)) begin
					e.mode = EV_TIMEOUT;
				end else if (pick < 78) begin
					e.mode = EV_PACKET;
					e.rx_kind = RX_CONACC;
					e.rx_session = cur_session;
				end else if (pick < 88) begin
					e.mode = EV_TIMEOUT;
				end else if (pick < 93) begin
					e.mode = EV_PACKET;
					e.rx_kind = RX_CONACC;
				end
			end
			PH_SENDING: begin
				if (pick < 88) e.mode = EV_READY;
			end
			PH_WAIT_ACC: begin
				if (pick < 70) begin
					e.mode = EV_PACKET;
					e.rx_kind = RX_ACC;
					e.rx_session = cur_session;
					e.rx_number = pkt_num;
				end else if (pick < 82) begin
					e.mode = EV_TIMEOUT;
				end else if (pick < 86) begin
					e.mode = EV_PACKET;
					e.rx_kind = RX_ACC;
					e.rx_session = cur_session;
					e.rx_number = pkt_num + 32'($urandom_range(1, 3));
				end else if (pick < 88) begin
					e.mode = EV_PACKET;
					e.rx_kind = RX_ACC;
					e.rx_number = pkt_num;
				end else if (pick < 91) begin
					e.mode = EV_PACKET;
					e.rx_kind = RX_RJT;
					e.rx_session = cur_session;
				end
			end
			PH_WAIT_RCVD: begin
				if (pick < 80) begin
					e.mode = EV_PACKET;
					e.rx_kind = RX_RCVD;
					e.rx_session = cur_session;
				end else if (pick < 85) begin
					e.mode = EV_TIMEOUT;
				end else if (pick < 89) begin
					e.mode = EV_PACKET;
					e.rx_kind = RX_RCVD;
				end
			end
			default: ;
		endcase
		return e;
	endfunction

	task automatic add_row(evt_t e, logic typed, res_t r);
		vector_t v;
		v.e = e;
		v.typed = typed;
		v.r = r;
		dir_rows.push_back(v);
	endtask

	// Offer one event word, wait for it to be taken, queue its result
	task automatic issue_event(evt_t e, logic typed, res_t typed_res);
		int gap;
		logic [2:0] prev_ph;
		if (!quiet && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			evt_valid <= 1'b0;
			gap = $urandom_range(1, 19);
			repeat (gap) @(posedge clk);
		end
		evt <= e;
		evt_valid <= 1'b1;
		do @(posedge clk); while (evt_stall);
		prev_ph = ph;
		step_sender(e);
		awaited_results.push_back(typed ? typed_res : pred);
		n_events++;
		if (!pred_ignored) n_live++;
		if (e.mode == EV_START && !pred_ignored) n_starts++;
		if (ph == PH_DONE && prev_ph != PH_DONE) n_done++;
		if (ph == PH_FAILED && prev_ph != PH_FAILED) n_failed++;
	endtask

	// cfg_valid is left high; the caller lowers it after the last write
	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_RELIABLE: cfg_reliable = data[0];
			REG_MAX_RETX: cfg_max_retx = data[7:0];
			REG_CHUNK:    cfg_chunk = data;
			default: ;
		endcase
	endtask

	task automatic configure(logic rel, logic [7:0] retx, logic [15:0] chunk, logic spare);
		logic [31:0] rnd;
		rnd = $urandom;
		// junk in the unused upper bits must be dropped
		write_reg(REG_RELIABLE, {rnd[15:1], rel});
		write_reg(REG_MAX_RETX, {rnd[31:24], retx});
		write_reg(REG_CHUNK, chunk);
		if (spare) write_reg(REG_UNUSED, rnd[31:16]);
		cfg_valid <= 1'b0;
	endtask

	// Receiver backpressure in bursts
	always @(posedge clk) begin
		if (stall_left == 0 && !quiet && stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
			stall_left = $urandom_range(1, 19);
		if (stall_left != 0) begin
			res_stall <= 1'b1;
			stall_left--;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// Result checker
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			n_checked++;
			if (awaited_results.size() == 0) begin
				failures++;
				if (shown < MAX_SHOWN) begin
					shown++;
					$display("unexpected result word: %s", describe(res));
				end
			end else begin
				want = awaited_results.pop_front();
				if (res !== want) begin
					failures++;
					if (shown < MAX_SHOWN) begin
						shown++;
						$display("result mismatch at %0t", $realtime);
						$display("  expected %s", describe(want));
						$display("  actual   %s", describe(res));
					end
				end
			end
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("Verification failed");
		$finish;
	end

	initial begin
		int p;
		int live_target;
		int drain;
		logic rel;
		logic [7:0] retx;
		logic [15:0] chunk;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at reset defaults: idle behavior, extremes, failure paths
		add_row(event_word(EV_TIMEOUT, '0, '0, RX_CONACC, '0, '0), 1'b1,
			result_word(KIND_NONE, '0, '0, '0, '0, ST_BUSY, '0));
		add_row(event_word(EV_READY, 32'd7, 64'd7, RX_ACC, '0, '0), 1'b0, '0);
		add_row(event_word(EV_START, '0, ONES64, RX_OTHER, '0, '0), 1'b1,
			result_word(KIND_CONN, ONES64, '0, '0, '0, ST_BUSY, '0));
		// zero length skips straight to the RCVD wait
		add_row(event_word(EV_PACKET, '0, '0, RX_CONACC, ONES64, '0), 1'b0, '0);
		add_row(event_word(EV_PACKET, '0, '0, RX_RCVD, ONES64, '0), 1'b1,
			result_word(KIND_NONE, '0, '0, '0, '0, ST_DONE, '0));
		add_row(event_word(EV_START, ONES32, '0, RX_CONACC, ONES64, ONES32), 1'b1,
			result_word(KIND_CONN, '0, '0, ONES32, '0, ST_BUSY, '0));
		add_row(event_word(EV_TIMEOUT, '0, '0, RX_CONACC, '0, '0), 1'b0, '0);
		// start while busy is dropped
		add_row(event_word(EV_START, 32'd5, 64'd5, RX_CONACC, '0, '0), 1'b0, '0);
		add_row(event_word(EV_PACKET, '0, '0, RX_CONACC, '0, '0), 1'b0, '0);
		add_row(event_word(EV_READY, '0, '0, RX_ACC, '0, '0), 1'b0, '0);
		add_row(event_word(EV_PACKET, '0, '0, RX_ACC, '0, '0), 1'b0, '0);
		// unused kind counts as a stray packet, then retries run out
		add_row(event_word(EV_PACKET, '0, '0, RX_SPARE, '0, '0), 1'b0, '0);
		add_row(event_word(EV_TIMEOUT, '0, '0, RX_ACC, '0, '0), 1'b0, '0);
		add_row(event_word(EV_PACKET, '0, '0, RX_ACC, '0, ONES32), 1'b0, '0);
		add_row(event_word(EV_TIMEOUT, '0, '0, RX_ACC, '0, '0), 1'b0, '0);
		add_row(event_word(EV_START, 32'd1, 64'h0123_4567_89AB_CDEF, RX_ACC, '0, '0),
			1'b0, '0);
		add_row(event_word(EV_PACKET, '0, '0, RX_CONACC, ONES64, '0), 1'b0, '0);
		add_row(event_word(EV_START, 32'd2048, 64'd7, RX_ACC, '0, '0), 1'b0, '0);
		add_row(event_word(EV_PACKET, '0, '0, RX_CONRJT, 64'd7, '0), 1'b0, '0);
		add_row(event_word(EV_START, 32'd1, 64'd9, RX_ACC, '0, '0), 1'b0, '0);
		add_row(event_word(EV_PACKET, '0, '0, RX_CONACC, 64'd9, '0), 1'b0, '0);
		add_row(event_word(EV_PACKET, '0, '0, RX_RJT, 64'd9, '0), 1'b0, '0);
		add_row(event_word(EV_START, 32'd0, 64'd3, RX_ACC, '0, '0), 1'b0, '0);
		add_row(event_word(EV_PACKET, '0, '0, RX_CONACC, 64'd3, '0), 1'b0, '0);
		add_row(event_word(EV_PACKET, '0, '0, RX_OTHER, 64'd3, '0), 1'b0, '0);
		add_row(event_word(EV_START, 32'd1, 64'd2, RX_ACC, '0, '0), 1'b0, '0);
		add_row(event_word(EV_PACKET, '0, '0, RX_CONACC, 64'd2, '0), 1'b0, '0);
		add_row(event_word(EV_PACKET, '0, '0, RX_ACC, 64'd2, '0), 1'b0, '0);
		add_row(event_word(EV_PACKET, '0, '0, RX_RCVD, 64'd5, '0), 1'b0, '0);
		n_directed = dir_rows.size();
		foreach (dir_rows[i]) issue_event(dir_rows[i].e, dir_rows[i].typed, dir_rows[i].r);

		// Random phases, each under its own register setting
		for (p = 0; p < N_PHASES; p++) begin
			evt_valid <= 1'b0;
			while (awaited_results.size() != 0) @(posedge clk);
			case (p)
				0: begin rel = 1'b1; retx = 8'd3;   chunk = 16'd64;    end
				1: begin rel = 1'b0; retx = 8'd3;   chunk = 16'd100;   end
				2: begin rel = 1'b1; retx = 8'd0;   chunk = 16'd1;     end
				3: begin rel = 1'b0; retx = 8'd255; chunk = 16'd0;     end
				4: begin rel = 1'b1; retx = 8'd255; chunk = 16'd65535; end
				5: begin rel = 1'b1; retx = 8'd1;   chunk = 16'd0;     end
				6: begin rel = 1'b0; retx = 8'd0;   chunk = 16'd65535; end
				8: begin rel = 1'b1; retx = 8'd2;   chunk = 16'd7;     end
				10: begin rel = 1'b0; retx = 8'd1;  chunk = 16'd1;     end
				11: begin rel = 1'b1; retx = 8'd3;  chunk = 16'd16;    end
				default: begin
					rel = 1'($urandom_range(0, 1));
					retx = 8'($urandom_range(0, 255));
					chunk = 16'($urandom_range(1, 300));
				end
			endcase
			configure(rel, retx, chunk, 1'(p % 2));
			case (p % 3)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 10; stall_pct = 3;  end
				default: begin idle_pct = 30; stall_pct = 10; end
			endcase
			if (p == N_PHASES - 1) quiet = 1'b1;
			live_target = n_live + ITEMS_PER_PHASE;
			while (n_live < live_target) issue_event(next_stimulus(), 1'b0, '0);
		end
		evt_valid <= 1'b0;

		drain = 0;
		while (awaited_results.size() != 0 && drain < 2000) begin
			@(posedge clk);
			drain++;
		end
		repeat (4) @(posedge clk);
		failures += awaited_results.size();

		$display("%0d event words (%0d directed), %0d results checked over %0d settings",
			n_events, n_directed, n_checked, N_PHASES + 1);
		$display("%0d transfers started, %0d completed, %0d failed, %0d timeouts, %0d errors",
			n_starts, n_done, n_failed, timeout_total, failures);
		if (failures == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+src
src/sws_pkg.sv
src/sws_fsm.sv
src/sws_obuf.sv
src/stop_and_wait_sender.sv
tb/testbench.sv
